@@ sv/alternating_range_address_mapper_macros.svh @@
`ifndef ALTERNATING_RANGE_ADDRESS_MAPPER_MACROS_SVH
`define ALTERNATING_RANGE_ADDRESS_MAPPER_MACROS_SVH

// Checks that a condition is followed by a consequence, sampled on clk, off during reset.
`define ARAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition never holds, sampled on clk, off during reset.
`define ARAM_ASSERT_NEVER(lbl, bad, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error(msg);

`endif

@@ sv/arm_pkg.sv @@
`default_nettype none

package arm_pkg;

    localparam int MAX_SPLITS    = 6;
    localparam int CFG_IDX_BITS  = 3;
    localparam int SP_IDX_BITS   = 3;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = 1;
    localparam int FIFO_CNT_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MEMORY_SIZE = 3'd6;

    typedef enum logic {
        TBL_IDLE,
        TBL_BUILD
    } tbl_state_t;

    typedef struct packed {
        logic routed_type;
        logic goes_upper;
        logic out_of_range;
    } arm_flags_t;

    typedef struct packed {
        logic full;
        logic empty;
    } arm_fifo_stat_t;

endpackage

`default_nettype wire

@@ sv/arm_tbl.sv @@
`default_nettype none

module arm_tbl #(
    parameter int NUM_SPLITS = 6,
    parameter int ADDR_BITS  = 32,
    parameter int SECT_BITS  = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [arm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [ADDR_BITS-1:0]             cfg_data,
    output logic                                  busy,
    output logic [ADDR_BITS-1:0]                  msize,
    output logic [ADDR_BITS-1:0]                  bnd  [NUM_SPLITS],
    output logic [ADDR_BITS-1:0]                  base [NUM_SPLITS+1],
    output logic [ADDR_BITS-1:0]                  offs [NUM_SPLITS+1]
);
    import arm_pkg::*;

    logic [ADDR_BITS-1:0] sp_reg [MAX_SPLITS];
    logic [ADDR_BITS-1:0] msize_reg;
    tbl_state_t           state_reg, state_next;
    logic [SECT_BITS-1:0] k_reg;
    logic [ADDR_BITS-1:0] prev_reg;
    logic [ADDR_BITS-1:0] acc_reg [2];
    logic [ADDR_BITS-1:0] base_reg [NUM_SPLITS+1];
    logic [ADDR_BITS-1:0] offs_reg [NUM_SPLITS+1];

    logic                   is_split;
    logic [SP_IDX_BITS-1:0] sp_idx;
    logic [ADDR_BITS-1:0]   sp_val;
    logic [ADDR_BITS-1:0]   grown;
    logic [ADDR_BITS-1:0]   clamped;
    logic [ADDR_BITS-1:0]   end_val;
    logic [ADDR_BITS-1:0]   size;
    logic                   side;
    logic                   last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SPLITS; i++)
            begin
                sp_reg[i] <= '0;
            end
            msize_reg <= ADDR_BITS'(32'hFFFF_FFFF);
        end
        else if (cfg_we)
        begin
            if (cfg_index < CFG_MEMORY_SIZE)
            begin
                sp_reg[SP_IDX_BITS'(cfg_index)] <= cfg_data;
            end
            else if (cfg_index == CFG_MEMORY_SIZE)
            begin
                msize_reg <= cfg_data;
            end
        end
    end

    // One section boundary is settled per cycle: running maximum, clamped to the size.
    always_comb
    begin
        is_split = (k_reg < SECT_BITS'(NUM_SPLITS));
        sp_idx   = is_split ? SP_IDX_BITS'(k_reg) : '0;
        sp_val   = sp_reg[sp_idx];
        grown    = (sp_val > prev_reg) ? sp_val : prev_reg;
        clamped  = (grown > msize_reg) ? msize_reg : grown;
        end_val  = is_split ? clamped : msize_reg;
        size     = end_val - prev_reg;
        side     = k_reg[0];
        last     = (k_reg == SECT_BITS'(NUM_SPLITS));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TBL_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = TBL_BUILD;
                end
            end
            TBL_BUILD:
            begin
                if (!cfg_we && last)
                begin
                    state_next = TBL_IDLE;
                end
            end
            default:
            begin
                state_next = TBL_BUILD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TBL_BUILD;
            k_reg      <= '0;
            prev_reg   <= '0;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                k_reg      <= '0;
                prev_reg   <= '0;
                acc_reg[0] <= '0;
                acc_reg[1] <= '0;
            end
            else if (state_reg == TBL_BUILD)
            begin
                k_reg         <= last ? k_reg : k_reg + SECT_BITS'(1);
                prev_reg      <= end_val;
                acc_reg[side] <= acc_reg[side] + size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cfg_we && state_reg == TBL_BUILD)
        begin
            base_reg[k_reg] <= prev_reg;
            offs_reg[k_reg] <= acc_reg[side];
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_SPLITS; j++)
        begin
            bnd[j] = base_reg[j+1];
        end
        for (int j = 0; j <= NUM_SPLITS; j++)
        begin
            base[j] = base_reg[j];
            offs[j] = offs_reg[j];
        end
    end

    assign busy  = (state_reg == TBL_BUILD);
    assign msize = msize_reg;

endmodule

`default_nettype wire

@@ sv/arm_front.sv @@
`default_nettype none

module arm_front #(
    parameter int NUM_SPLITS = 6,
    parameter int ADDR_BITS  = 32,
    parameter int SECT_BITS  = 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 req_type,
    input  wire logic [ADDR_BITS-1:0] address,
    input  wire logic [ADDR_BITS-1:0] msize,
    input  wire logic [ADDR_BITS-1:0] bnd  [NUM_SPLITS],
    input  wire logic [ADDR_BITS-1:0] base [NUM_SPLITS+1],
    output logic                      push,
    output arm_pkg::arm_flags_t       push_flags,
    output logic [SECT_BITS-1:0]      push_sect,
    output logic [ADDR_BITS-1:0]      push_rel
);
    import arm_pkg::*;

    logic                  s1_valid_reg;
    logic                  s1_type_reg;
    logic [ADDR_BITS-1:0]  s1_addr_reg;
    logic                  s2_valid_reg;
    logic                  s2_type_reg;
    logic [ADDR_BITS-1:0]  s2_addr_reg;
    logic [NUM_SPLITS-1:0] s2_ge_reg;
    logic                  s2_oor_reg;

    logic [NUM_SPLITS-1:0] ge_next;
    logic                  oor_next;
    logic [SECT_BITS-1:0]  sect;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_SPLITS; j++)
        begin
            ge_next[j] = (s1_addr_reg >= bnd[j]);
        end
        oor_next = (s1_addr_reg >= msize);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg <= req_type;
            s1_addr_reg <= address;
        end
        s2_type_reg <= s1_type_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_ge_reg   <= ge_next;
        s2_oor_reg  <= oor_next;
    end

    // Boundaries never decrease, so the compare bits form a thermometer code.
    always_comb
    begin
        sect = SECT_BITS'(NUM_SPLITS);
        for (int j = NUM_SPLITS - 1; j >= 0; j--)
        begin
            if (!s2_ge_reg[j])
            begin
                sect = SECT_BITS'(j);
            end
        end
    end

    assign push                    = s2_valid_reg;
    assign push_flags.routed_type  = s2_type_reg;
    assign push_flags.goes_upper   = sect[0];
    assign push_flags.out_of_range = s2_oor_reg;
    assign push_sect               = sect;
    assign push_rel                = s2_addr_reg - base[sect];

endmodule

`default_nettype wire

@@ sv/arm_fifo.sv @@
`default_nettype none

module arm_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output arm_pkg::arm_fifo_stat_t stat
);
    import arm_pkg::*;

    logic [WIDTH-1:0]         slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign stat.full  = (count_reg == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + FIFO_CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - FIFO_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ sv/arm_back.sv @@
`default_nettype none

module arm_back #(
    parameter int NUM_SPLITS = 6,
    parameter int ADDR_BITS  = 32,
    parameter int SECT_BITS  = 3,
    parameter int WIDTH      = 38
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire arm_pkg::arm_fifo_stat_t stat,
    input  wire logic [WIDTH-1:0]     rdata,
    input  wire logic [ADDR_BITS-1:0] offs [NUM_SPLITS+1],
    output logic                      pop,
    output logic                      done,
    output logic                      routed_type,
    output logic                      goes_upper,
    output logic [ADDR_BITS-1:0]      child_address,
    output logic                      out_of_range
);
    import arm_pkg::*;

    arm_flags_t           flags;
    logic [SECT_BITS-1:0] sect;
    logic [ADDR_BITS-1:0] rel;

    logic                 done_reg;
    logic                 routed_type_reg;
    logic                 goes_upper_reg;
    logic [ADDR_BITS-1:0] child_reg;
    logic                 oor_reg;

    assign {flags, sect, rel} = rdata;
    assign pop                = !stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pop;
        end
    end

    // An address past the end routes nowhere: lower child, address zero.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            routed_type_reg <= flags.routed_type;
            goes_upper_reg  <= flags.goes_upper && !flags.out_of_range;
            child_reg       <= flags.out_of_range ? '0 : offs[sect] + rel;
            oor_reg         <= flags.out_of_range;
        end
    end

    assign done          = done_reg;
    assign routed_type   = routed_type_reg;
    assign goes_upper    = goes_upper_reg;
    assign child_address = child_reg;
    assign out_of_range  = oor_reg;

endmodule

`default_nettype wire

@@ sv/alternating_range_address_mapper.sv @@
// Channel   Handshake            Fields
// request   start / busy         req_type, address
// result    done (strobe)        routed_type, goes_upper, child_address, out_of_range
// config    cfg_we               cfg_index, cfg_data
//
// One word is accepted per cycle while busy is low; each result passes through the
// classification stages, the queue and the output registers before done rises.
// After reset and after every configuration write, busy stays high while the section
// table is rebuilt, one boundary per cycle; a further write restarts the rebuild.
// The receiver cannot stall; the queue between classification and translation drains
// one word every cycle while it holds any.
`default_nettype none
`include "alternating_range_address_mapper_macros.svh"

module alternating_range_address_mapper #(
    parameter int NUM_SPLITS = 6,
    parameter int ADDR_BITS  = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             req_type,
    input  wire logic [ADDR_BITS-1:0]             address,
    output logic                                  done,
    output logic                                  routed_type,
    output logic                                  goes_upper,
    output logic [ADDR_BITS-1:0]                  child_address,
    output logic                                  out_of_range,
    input  wire logic                             cfg_we,
    input  wire logic [arm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [ADDR_BITS-1:0]             cfg_data
);
    import arm_pkg::*;

    localparam int SECT_BITS = $clog2(NUM_SPLITS + 1);
    localparam int Q_WIDTH   = $bits(arm_flags_t) + SECT_BITS + ADDR_BITS;

    logic                 accept;
    logic [ADDR_BITS-1:0] msize;
    logic [ADDR_BITS-1:0] bnd  [NUM_SPLITS];
    logic [ADDR_BITS-1:0] base [NUM_SPLITS+1];
    logic [ADDR_BITS-1:0] offs [NUM_SPLITS+1];

    logic                 push;
    arm_flags_t           push_flags;
    logic [SECT_BITS-1:0] push_sect;
    logic [ADDR_BITS-1:0] push_rel;
    logic [Q_WIDTH-1:0]   q_wdata;
    logic [Q_WIDTH-1:0]   q_rdata;
    arm_fifo_stat_t       q_stat;
    logic                 pop;

    assign accept  = start && !busy;
    assign q_wdata = {push_flags, push_sect, push_rel};

    arm_tbl #(
        .NUM_SPLITS (NUM_SPLITS),
        .ADDR_BITS  (ADDR_BITS),
        .SECT_BITS  (SECT_BITS)
    ) u_tbl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .msize     (msize),
        .bnd       (bnd),
        .base      (base),
        .offs      (offs)
    );

    arm_front #(
        .NUM_SPLITS (NUM_SPLITS),
        .ADDR_BITS  (ADDR_BITS),
        .SECT_BITS  (SECT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .address    (address),
        .msize      (msize),
        .bnd        (bnd),
        .base       (base),
        .push       (push),
        .push_flags (push_flags),
        .push_sect  (push_sect),
        .push_rel   (push_rel)
    );

    arm_fifo #(
        .WIDTH (Q_WIDTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    arm_back #(
        .NUM_SPLITS (NUM_SPLITS),
        .ADDR_BITS  (ADDR_BITS),
        .SECT_BITS  (SECT_BITS),
        .WIDTH      (Q_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .stat          (q_stat),
        .rdata         (q_rdata),
        .offs          (offs),
        .pop           (pop),
        .done          (done),
        .routed_type   (routed_type),
        .goes_upper    (goes_upper),
        .child_address (child_address),
        .out_of_range  (out_of_range)
    );

    `ARAM_ASSERT_IMP(a_latency, accept, ##4 done, "accepted word produced no result")
    `ARAM_ASSERT_NEVER(a_q_overflow, push && q_stat.full && !pop, "queue overflow")
    `ARAM_ASSERT_IMP(a_oor_zero, done && out_of_range, !goes_upper && child_address == '0, "out-of-range result not cleared")
    `ARAM_ASSERT_IMP(a_no_config_in_flight, push, !busy, "table rebuilt with word in flight")

endmodule

`default_nettype wire
